[rtl/shisc_pkg.sv]
// Package for the sketch hit indel/substitution check unit.
// Holds the beat and result types, reason codes, register indexes and helpers.
// No dependencies.
package shisc_pkg;

  localparam int OffsetWidth = 17;
  localparam int CountWidth  = 16;
  localparam int LengthWidth = 16;
  localparam int RateWidth   = 16;
  localparam int KmerWidth   = 7;
  localparam int ProdWidth   = LengthWidth + RateWidth;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 16;

  localparam logic [KmerWidth-1:0] KmerReset = 7'd16;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_KMER_LENGTH       = 2'd0,
    CFG_INDEL_RATE        = 2'd1,
    CFG_SUBSTITUTION_RATE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REASON_PASS    = 2'd0,
    REASON_NO_ZERO = 2'd1,
    REASON_INDELS  = 2'd2,
    REASON_SUBS    = 2'd3
  } reason_t;

  // Registered element beat; Q16.16 limit products are formed before the register.
  typedef struct packed {
    logic                          segment;
    logic                          matched;
    logic signed [OffsetWidth-1:0] offset;
    logic                          last_seg;
    logic                          last_cand;
    logic [ProdWidth-1:0]          indel_prod;
    logic [ProdWidth-1:0]          sub_prod;
  } item_t;

  typedef struct packed {
    logic    pass;
    reason_t reason;
    logic    failed_segment;
  } result_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v == {CountWidth{1'b1}}) ? v : v + CountWidth'(1);
  endfunction

  // ceil(prod / 65536)
  function automatic logic [ProdWidth-RateWidth:0] ceil_q16(input logic [ProdWidth-1:0] p);
    logic [ProdWidth:0] sum;
    sum = {1'b0, p} + (ProdWidth+1)'({RateWidth{1'b1}});
    ceil_q16 = sum[ProdWidth:RateWidth];
  endfunction

endpackage

[rtl/sketch_hit_indel_substitution_check_unit.sv]
// Top level of the sketch hit indel/substitution check unit.
// Depends on shisc_pkg, shisc_in_stage and shisc_seg_track.
//
// Usage:
//   Sketch elements of one candidate arrive on the in_ channel, one beat per
//   element, segment by segment; last_in_segment closes a segment and
//   last_in_candidate closes segment and candidate. A beat moves when valid is
//   high and stall is low. One verdict beat (pass, reason, failed_segment)
//   leaves on the out_ channel for each last_in_candidate beat; other beats
//   give no result.
//   The verdict of a closing beat in the input register is registered on out_.
//   Throughput: one element per cycle while in_stall is low, set by the input
//   register before the single state-update stage; limit multiplies precede it.
//   When out_stall holds a verdict and a further closing beat is waiting in
//   the input register, in_stall rises until the verdict is taken; beats that
//   give no result keep flowing regardless.
//   User writes registers via cfg_ (always ready) only when idle; unchecked.
//   Reset clears all tracking state and loads kmer_length 16, both rates 0.
module sketch_hit_indel_substitution_check_unit #(
  parameter int POSITION_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_segment,
  input  logic                                     in_matched,
  input  logic signed [shisc_pkg::OffsetWidth-1:0] in_offset,
  input  logic [POSITION_BITS-1:0]                 in_position,
  input  logic [shisc_pkg::LengthWidth-1:0]        in_seg_length,
  input  logic                                     in_last_in_segment,
  input  logic                                     in_last_in_candidate,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     out_pass,
  output logic [1:0]                               out_reason,
  output logic                                     out_failed_segment,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [shisc_pkg::CfgIdxWidth-1:0]        cfg_index,
  input  logic [shisc_pkg::CfgDataWidth-1:0]       cfg_data
);

  logic [shisc_pkg::KmerWidth-1:0]  kmer_r;
  logic [shisc_pkg::RateWidth-1:0]  indel_rate_r;
  logic [shisc_pkg::RateWidth-1:0]  sub_rate_r;

  logic                             s1_valid;
  shisc_pkg::item_t                 s1_item;
  logic [POSITION_BITS-1:0]         s1_position;
  logic                             s1_advance;
  logic                             in_take;
  shisc_pkg::result_t               s1_result;

  logic                             out_valid_r, out_valid_nxt;
  shisc_pkg::result_t               out_res_r;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!s1_item.last_cand || !out_valid_r || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_r       <= shisc_pkg::KmerReset;
      indel_rate_r <= '0;
      sub_rate_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        shisc_pkg::CFG_KMER_LENGTH:       kmer_r       <= cfg_data[shisc_pkg::KmerWidth-1:0];
        shisc_pkg::CFG_INDEL_RATE:        indel_rate_r <= cfg_data;
        shisc_pkg::CFG_SUBSTITUTION_RATE: sub_rate_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  shisc_in_stage #(
    .POSITION_BITS(POSITION_BITS)
  ) u_in_stage (
    .clk                  (clk),
    .rst_n                (rst_n),
    .take                 (in_take),
    .drain                (s1_advance),
    .in_segment           (in_segment),
    .in_matched           (in_matched),
    .in_offset            (in_offset),
    .in_position          (in_position),
    .in_seg_length        (in_seg_length),
    .in_last_in_segment   (in_last_in_segment),
    .in_last_in_candidate (in_last_in_candidate),
    .indel_rate           (indel_rate_r),
    .substitution_rate    (sub_rate_r),
    .valid                (s1_valid),
    .item                 (s1_item),
    .position             (s1_position)
  );

  shisc_seg_track #(
    .POSITION_BITS(POSITION_BITS)
  ) u_seg_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_advance),
    .item        (s1_item),
    .position    (s1_position),
    .kmer_length (kmer_r),
    .result      (s1_result)
  );

  always_comb begin
    if (s1_advance && s1_item.last_cand) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_item.last_cand) begin
      out_res_r <= s1_result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pass           = out_res_r.pass;
  assign out_reason         = out_res_r.reason;
  assign out_failed_segment = out_res_r.failed_segment;

  // stall only when a closing beat is blocked by a held verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && s1_item.last_cand && out_valid_r && out_stall))
    else $error("input stalled without a held verdict");

  a_verdict_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_item.last_cand) |=> out_valid_r)
    else $error("closing beat gave no verdict");

  a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pass) |->
      (out_reason == shisc_pkg::REASON_PASS && !out_failed_segment))
    else $error("pass verdict carries a reason or segment");

  a_fail_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pass) |-> (out_reason != shisc_pkg::REASON_PASS))
    else $error("fail verdict without reason");

endmodule

[rtl/shisc_in_stage.sv]
// Input register of the check unit: captures one element beat and the
// two Q16.16 limit products of its segment length. Depends on shisc_pkg.
module shisc_in_stage #(
  parameter int POSITION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  take,
  input  logic                                  drain,
  input  logic                                  in_segment,
  input  logic                                  in_matched,
  input  logic signed [shisc_pkg::OffsetWidth-1:0] in_offset,
  input  logic [POSITION_BITS-1:0]              in_position,
  input  logic [shisc_pkg::LengthWidth-1:0]     in_seg_length,
  input  logic                                  in_last_in_segment,
  input  logic                                  in_last_in_candidate,
  input  logic [shisc_pkg::RateWidth-1:0]       indel_rate,
  input  logic [shisc_pkg::RateWidth-1:0]       substitution_rate,
  output logic                                  valid,
  output shisc_pkg::item_t                      item,
  output logic [POSITION_BITS-1:0]              position
);

  logic                                  valid_r;
  logic                                  valid_nxt;
  shisc_pkg::item_t                      item_r;
  shisc_pkg::item_t                      item_nxt;
  logic [POSITION_BITS-1:0]              position_r;
  logic [shisc_pkg::LengthWidth-1:0]     len_m1;

  always_comb begin
    len_m1 = (in_seg_length == '0) ? '0 : in_seg_length - shisc_pkg::LengthWidth'(1);
    item_nxt.segment    = in_segment;
    item_nxt.matched    = in_matched;
    item_nxt.offset     = in_offset;
    item_nxt.last_seg   = in_last_in_segment;
    item_nxt.last_cand  = in_last_in_candidate;
    item_nxt.indel_prod = shisc_pkg::ProdWidth'(len_m1) * shisc_pkg::ProdWidth'(indel_rate);
    item_nxt.sub_prod   = shisc_pkg::ProdWidth'(in_seg_length) *
                          shisc_pkg::ProdWidth'(substitution_rate);
    if (take) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r     <= item_nxt;
      position_r <= in_position;
    end
  end

  assign valid    = valid_r;
  assign item     = item_r;
  assign position = position_r;

endmodule

[rtl/shisc_seg_track.sv]
// Per-segment tracking (offset changes, zero offsets, mismatch intervals)
// and per-candidate verdict state. Depends on shisc_pkg.
module shisc_seg_track #(
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  shisc_pkg::item_t                  item,
  input  logic [POSITION_BITS-1:0]          position,
  input  logic [shisc_pkg::KmerWidth-1:0]   kmer_length,
  output shisc_pkg::result_t                result
);

  localparam int CW = shisc_pkg::CountWidth;
  localparam int EW = POSITION_BITS + 1;

  logic                              seen_r, seen_nxt;
  logic signed [shisc_pkg::OffsetWidth-1:0] prev_off_r, prev_off_nxt;
  logic [CW-1:0]                     later_r, later_nxt;
  logic [CW-1:0]                     zero_r, zero_nxt;
  logic [CW-1:0]                     chg_r, chg_nxt;
  logic [CW-1:0]                     ivl_cnt_r, ivl_cnt_nxt;
  logic                              have_ivl_r, have_ivl_nxt;
  logic [POSITION_BITS-1:0]          ivl_start_r, ivl_start_nxt;
  logic [EW-1:0]                     ivl_end_r, ivl_end_nxt;
  shisc_pkg::reason_t                indel_verdict_r, indel_verdict_nxt;
  logic                              indel_seg_r, indel_seg_nxt;
  logic                              sub_failed_r, sub_failed_nxt;
  logic                              sub_seg_r, sub_seg_nxt;

  logic [shisc_pkg::KmerWidth-1:0]   k_eff;
  logic [EW-1:0]                     pos_ext;
  logic [EW-1:0]                     start_plus_k;
  logic                              open_ivl;
  logic [shisc_pkg::ProdWidth-shisc_pkg::RateWidth:0] indel_lim;
  logic [shisc_pkg::ProdWidth-shisc_pkg::RateWidth:0] sub_lim;

  always_comb begin
    k_eff        = (kmer_length == '0) ? shisc_pkg::KmerWidth'(1) : kmer_length;
    pos_ext      = {1'b0, position};
    start_plus_k = {1'b0, ivl_start_r} + EW'(k_eff);
    open_ivl     = !have_ivl_r || (pos_ext > ivl_end_r) || (pos_ext >= start_plus_k);
    indel_lim    = shisc_pkg::ceil_q16(item.indel_prod);
    sub_lim      = shisc_pkg::ceil_q16(item.sub_prod);

    seen_nxt          = seen_r;
    prev_off_nxt      = prev_off_r;
    later_nxt         = later_r;
    zero_nxt          = zero_r;
    chg_nxt           = chg_r;
    ivl_cnt_nxt       = ivl_cnt_r;
    have_ivl_nxt      = have_ivl_r;
    ivl_start_nxt     = ivl_start_r;
    ivl_end_nxt       = ivl_end_r;
    indel_verdict_nxt = indel_verdict_r;
    indel_seg_nxt     = indel_seg_r;
    sub_failed_nxt    = sub_failed_r;
    sub_seg_nxt       = sub_seg_r;

    if (item.matched) begin
      if (!seen_r) begin
        seen_nxt     = 1'b1;
        prev_off_nxt = item.offset;
        zero_nxt     = (item.offset == '0) ? CW'(1) : '0;
      end else begin
        later_nxt = shisc_pkg::sat_inc(later_r);
        if (item.offset != prev_off_r) begin
          chg_nxt = shisc_pkg::sat_inc(chg_r);
        end
        if (item.offset == '0) begin
          zero_nxt = shisc_pkg::sat_inc(zero_r);
        end
        prev_off_nxt = item.offset;
      end
    end else if (open_ivl) begin
      ivl_cnt_nxt   = shisc_pkg::sat_inc(ivl_cnt_r);
      have_ivl_nxt  = 1'b1;
      ivl_start_nxt = position;
      ivl_end_nxt   = pos_ext + EW'(k_eff) - EW'(1);
    end else begin
      ivl_end_nxt = pos_ext;
    end

    if (item.last_seg || item.last_cand) begin
      if (indel_verdict_r == shisc_pkg::REASON_PASS && later_nxt != '0) begin
        if (zero_nxt == '0) begin
          indel_verdict_nxt = shisc_pkg::REASON_NO_ZERO;
          indel_seg_nxt     = item.segment;
        end else if ({1'b0, chg_nxt} > indel_lim) begin
          indel_verdict_nxt = shisc_pkg::REASON_INDELS;
          indel_seg_nxt     = item.segment;
        end
      end
      if (!sub_failed_r && ({1'b0, ivl_cnt_nxt} > sub_lim)) begin
        sub_failed_nxt = 1'b1;
        sub_seg_nxt    = item.segment;
      end
      seen_nxt      = 1'b0;
      prev_off_nxt  = '0;
      later_nxt     = '0;
      zero_nxt      = '0;
      chg_nxt       = '0;
      ivl_cnt_nxt   = '0;
      have_ivl_nxt  = 1'b0;
      ivl_start_nxt = '0;
      ivl_end_nxt   = '0;
    end

    if (indel_verdict_nxt != shisc_pkg::REASON_PASS) begin
      result.pass           = 1'b0;
      result.reason         = indel_verdict_nxt;
      result.failed_segment = indel_seg_nxt;
    end else if (sub_failed_nxt) begin
      result.pass           = 1'b0;
      result.reason         = shisc_pkg::REASON_SUBS;
      result.failed_segment = sub_seg_nxt;
    end else begin
      result.pass           = 1'b1;
      result.reason         = shisc_pkg::REASON_PASS;
      result.failed_segment = 1'b0;
    end

    if (item.last_cand) begin
      indel_verdict_nxt = shisc_pkg::REASON_PASS;
      indel_seg_nxt     = 1'b0;
      sub_failed_nxt    = 1'b0;
      sub_seg_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r          <= 1'b0;
      prev_off_r      <= '0;
      later_r         <= '0;
      zero_r          <= '0;
      chg_r           <= '0;
      ivl_cnt_r       <= '0;
      have_ivl_r      <= 1'b0;
      ivl_start_r     <= '0;
      ivl_end_r       <= '0;
      indel_verdict_r <= shisc_pkg::REASON_PASS;
      indel_seg_r     <= 1'b0;
      sub_failed_r    <= 1'b0;
      sub_seg_r       <= 1'b0;
    end else if (advance) begin
      seen_r          <= seen_nxt;
      prev_off_r      <= prev_off_nxt;
      later_r         <= later_nxt;
      zero_r          <= zero_nxt;
      chg_r           <= chg_nxt;
      ivl_cnt_r       <= ivl_cnt_nxt;
      have_ivl_r      <= have_ivl_nxt;
      ivl_start_r     <= ivl_start_nxt;
      ivl_end_r       <= ivl_end_nxt;
      indel_verdict_r <= indel_verdict_nxt;
      indel_seg_r     <= indel_seg_nxt;
      sub_failed_r    <= sub_failed_nxt;
      sub_seg_r       <= sub_seg_nxt;
    end
  end

endmodule

[test/shisc_verdict_checker.sv]
// Verdict checker for the sketch hit indel/substitution check unit.
// Follows element and register beats, predicts each candidate's verdict and
// compares it with the out_ beats. Depends on shisc_pkg.
module shisc_verdict_checker #(
  parameter int PosBits = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  logic                                     in_stall,
  input  logic                                     in_segment,
  input  logic                                     in_matched,
  input  logic signed [shisc_pkg::OffsetWidth-1:0] in_offset,
  input  logic [PosBits-1:0]                       in_position,
  input  logic [shisc_pkg::LengthWidth-1:0]        in_seg_length,
  input  logic                                     in_last_in_segment,
  input  logic                                     in_last_in_candidate,
  input  logic                                     out_valid,
  input  logic                                     out_stall,
  input  logic                                     out_pass,
  input  logic [1:0]                               out_reason,
  input  logic                                     out_failed_segment,
  input  logic                                     cfg_valid,
  input  logic                                     cfg_ready,
  input  logic [shisc_pkg::CfgIdxWidth-1:0]        cfg_index,
  input  logic [shisc_pkg::CfgDataWidth-1:0]       cfg_data,
  output int unsigned                              fail_count,
  output int unsigned                              pending
);

  logic [shisc_pkg::KmerWidth-1:0]          kmer_len;
  logic [shisc_pkg::RateWidth-1:0]          indel_q16;
  logic [shisc_pkg::RateWidth-1:0]          subst_q16;
  logic                                     seen_hit;
  logic signed [shisc_pkg::OffsetWidth-1:0] prev_off;
  logic [shisc_pkg::CountWidth-1:0]         later_hits;
  logic [shisc_pkg::CountWidth-1:0]         zero_hits;
  logic [shisc_pkg::CountWidth-1:0]         off_changes;
  logic [shisc_pkg::CountWidth-1:0]         gap_count;
  logic                                     gap_open;
  logic [PosBits-1:0]                       gap_start;
  logic [PosBits:0]                         gap_end;
  shisc_pkg::reason_t                       indel_reason;
  logic                                     indel_seg;
  logic                                     subst_failed;
  logic                                     subst_seg;
  shisc_pkg::result_t                       verdict_q[$];
  int                                       errors = 0;

  function automatic logic [shisc_pkg::CountWidth-1:0] bump(
      input logic [shisc_pkg::CountWidth-1:0] v);
    return (v == '1) ? v : v + shisc_pkg::CountWidth'(1);
  endfunction

  // ceil(x * rate / 2^16)
  function automatic longint unsigned q16_ceil(input longint unsigned x,
                                               input longint unsigned rate);
    return (x * rate + 64'hFFFF) >> 16;
  endfunction

  function automatic void check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      errors++;
    end
  endfunction

  task automatic restart_segment();
    seen_hit    = 1'b0;
    prev_off    = '0;
    later_hits  = '0;
    zero_hits   = '0;
    off_changes = '0;
    gap_count   = '0;
    gap_open    = 1'b0;
    gap_start   = '0;
    gap_end     = '0;
  endtask

  task automatic restart_candidate();
    indel_reason = shisc_pkg::REASON_PASS;
    indel_seg    = 1'b0;
    subst_failed = 1'b0;
    subst_seg    = 1'b0;
  endtask

  always @(posedge clk) begin : predict_verdict
    shisc_pkg::result_t want;
    int                 k;
    int                 span_end;
    longint unsigned    lm1;
    if (!rst_n) begin
      kmer_len  = shisc_pkg::KmerReset;
      indel_q16 = '0;
      subst_q16 = '0;
      restart_segment();
      restart_candidate();
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict beat with none expected, actual pass=%0b reason=%0d seg=%0b",
                   $time, out_pass, out_reason, out_failed_segment);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          check_field("pass", int'(want.pass), int'(out_pass));
          check_field("reason", int'(want.reason), int'(out_reason));
          check_field("failed_segment", int'(want.failed_segment), int'(out_failed_segment));
        end
      end

      if (in_valid && !in_stall) begin
        k = (kmer_len == '0) ? 1 : int'(kmer_len);
        if (in_matched) begin
          if (!seen_hit) begin
            seen_hit  = 1'b1;
            prev_off  = in_offset;
            zero_hits = {{(shisc_pkg::CountWidth-1){1'b0}}, in_offset == '0};
          end else begin
            later_hits = bump(later_hits);
            if (in_offset != prev_off) off_changes = bump(off_changes);
            if (in_offset == '0) zero_hits = bump(zero_hits);
            prev_off = in_offset;
          end
        end else if (!gap_open || {1'b0, in_position} > gap_end ||
                     int'(in_position) >= int'(gap_start) + k) begin
          gap_count = bump(gap_count);
          gap_open  = 1'b1;
          gap_start = in_position;
          span_end  = int'(in_position) + k - 1;
          gap_end   = span_end[PosBits:0];
        end else begin
          gap_end = {1'b0, in_position};
        end

        if (in_last_in_segment || in_last_in_candidate) begin
          lm1 = (in_seg_length == '0) ? 64'd0 : 64'(in_seg_length) - 64'd1;
          if (indel_reason == shisc_pkg::REASON_PASS && later_hits != '0) begin
            if (zero_hits == '0) begin
              indel_reason = shisc_pkg::REASON_NO_ZERO;
              indel_seg    = in_segment;
            end else if (64'(off_changes) > q16_ceil(lm1, 64'(indel_q16))) begin
              indel_reason = shisc_pkg::REASON_INDELS;
              indel_seg    = in_segment;
            end
          end
          if (!subst_failed &&
              64'(gap_count) > q16_ceil(64'(in_seg_length), 64'(subst_q16))) begin
            subst_failed = 1'b1;
            subst_seg    = in_segment;
          end
          restart_segment();
        end

        if (in_last_in_candidate) begin
          if (indel_reason != shisc_pkg::REASON_PASS) begin
            want.pass           = 1'b0;
            want.reason         = indel_reason;
            want.failed_segment = indel_seg;
          end else if (subst_failed) begin
            want.pass           = 1'b0;
            want.reason         = shisc_pkg::REASON_SUBS;
            want.failed_segment = subst_seg;
          end else begin
            want.pass           = 1'b1;
            want.reason         = shisc_pkg::REASON_PASS;
            want.failed_segment = 1'b0;
          end
          verdict_q = {verdict_q, want};
          restart_candidate();
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          shisc_pkg::CFG_KMER_LENGTH:       kmer_len  = cfg_data[shisc_pkg::KmerWidth-1:0];
          shisc_pkg::CFG_INDEL_RATE:        indel_q16 = cfg_data[shisc_pkg::RateWidth-1:0];
          shisc_pkg::CFG_SUBSTITUTION_RATE: subst_q16 = cfg_data[shisc_pkg::RateWidth-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending    <= verdict_q.size();
  end

endmodule

[test/sketch_hit_indel_substitution_check_unit_tb.sv]
// Testbench top for the sketch hit indel/substitution check unit.
// Drives element and register beats with idling and back-pressure; the
// verdict checker does the comparing. Depends on shisc_pkg and shisc_verdict_checker.
module sketch_hit_indel_substitution_check_unit_tb;

  localparam int PosBits       = 16;
  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 400;
  localparam int Settle        = 4;

  logic                                     clk = 1'b0;
  logic                                     rst_n;
  logic                                     in_valid;
  logic                                     in_stall;
  logic                                     in_segment;
  logic                                     in_matched;
  logic signed [shisc_pkg::OffsetWidth-1:0] in_offset;
  logic [PosBits-1:0]                       in_position;
  logic [shisc_pkg::LengthWidth-1:0]        in_seg_length;
  logic                                     in_last_in_segment;
  logic                                     in_last_in_candidate;
  logic                                     out_valid;
  logic                                     out_stall;
  logic                                     out_pass;
  logic [1:0]                               out_reason;
  logic                                     out_failed_segment;
  logic                                     cfg_valid;
  logic                                     cfg_ready;
  logic [shisc_pkg::CfgIdxWidth-1:0]        cfg_index;
  logic [shisc_pkg::CfgDataWidth-1:0]       cfg_data;
  int unsigned                              fail_count;
  int unsigned                              pending;

  int in_gap_pct  = 0;
  int out_gap_pct = 0;
  int hold_left   = 0;
  int kmer_now    = 16;
  int items_sent  = 0;

  sketch_hit_indel_substitution_check_unit #(.POSITION_BITS(PosBits)) u_top (.*);
  shisc_verdict_checker #(.PosBits(PosBits)) u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall, or a long hold-off when asked
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_gap_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_elem(input int seg, input int hit, input int off, input int pos,
                           input int len, input int eos, input int eoc);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_segment           <= seg[0];
    in_matched           <= hit[0];
    in_offset            <= off[shisc_pkg::OffsetWidth-1:0];
    in_position          <= pos[PosBits-1:0];
    in_seg_length        <= len[shisc_pkg::LengthWidth-1:0];
    in_last_in_segment   <= eos[0];
    in_last_in_candidate <= eoc[0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic cfg_beat(input shisc_pkg::cfg_idx_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[shisc_pkg::CfgDataWidth-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input int kmer, input int indel, input int subst);
    cfg_beat(shisc_pkg::CFG_KMER_LENGTH, kmer);
    cfg_beat(shisc_pkg::CFG_INDEL_RATE, indel);
    cfg_beat(shisc_pkg::CFG_SUBSTITUTION_RATE, subst);
    cfg_valid <= 1'b0;
    kmer_now = kmer;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  function automatic int pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return int'($urandom_range(0, 8)) - 4;
    if (r < 90) return ($urandom_range(0, 1) != 0) ? 65535 : -65535;
    return int'($urandom_range(0, 131070)) - 65535;
  endfunction

  // one candidate of one or two segments; a few beats are scrambled
  task automatic send_candidate(input int max_elems);
    int   nseg, nel, len, pos, off, r, seg_bit, hit, eos;
    logic noise;
    nseg = $urandom_range(1, 2);
    off  = pick_offset();
    for (int s = 0; s < nseg; s++) begin
      nel = $urandom_range(1, max_elems);
      r   = $urandom_range(0, 99);
      if (r < 80)      len = $urandom_range(8, 200);
      else if (r < 92) len = $urandom_range(1, 8);
      else             len = $urandom_range(0, 65535);
      pos = ($urandom_range(0, 19) == 0) ? 65535 - int'($urandom_range(0, 200))
                                         : int'($urandom_range(0, 8));
      for (int e = 0; e < nel; e++) begin
        seg_bit = s & 1;
        hit     = int'($urandom_range(0, 99) < 65);
        eos     = int'((e == nel - 1) && (s + 1 < nseg || $urandom_range(0, 1) == 1));
        noise   = ($urandom_range(0, 99) < 8);
        if (hit != 0 && $urandom_range(0, 99) < 25) off = pick_offset();
        if (noise) begin
          seg_bit = int'($urandom_range(0, 1));
          pos     = int'($urandom_range(0, 65535));
          eos     = int'(eos != 0 || $urandom_range(0, 2) == 0);
        end
        send_elem(seg_bit, hit, noise ? pick_offset() : off, pos, len, eos,
                  int'(e == nel - 1 && s == nseg - 1));
        pos = pos + int'($urandom_range(0, kmer_now + 2));
      end
    end
  endtask

  initial begin
    int mark;
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_segment           <= 1'b0;
    in_matched           <= 1'b0;
    in_offset            <= '0;
    in_position          <= '0;
    in_seg_length        <= '0;
    in_last_in_segment   <= 1'b0;
    in_last_in_candidate <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_index            <= shisc_pkg::CFG_KMER_LENGTH;
    cfg_data             <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: k 16, both rates zero
    send_elem(0, 1, 0, 0, 1, 0, 1);
    send_elem(0, 1, 5, 0, 40, 0, 0);
    send_elem(0, 1, 5, 4, 40, 0, 1);
    send_elem(0, 1, 0, 0, 30, 0, 0);
    send_elem(0, 1, 3, 2, 30, 1, 0);
    send_elem(1, 0, 0, 0, 30, 0, 1);
    send_elem(0, 1, 0, 0, 50, 1, 0);
    send_elem(1, 0, 0, 65535, 65535, 0, 0);
    send_elem(1, 0, 0, 0, 65535, 0, 1);
    send_elem(0, 1, 0, 0, 0, 0, 0);
    send_elem(0, 1, 1, 0, 0, 0, 1);
    // segment label changes without closing the segment
    send_elem(0, 1, -65535, 0, 9, 0, 0);
    send_elem(1, 1, 65535, 3, 9, 0, 1);
    wait_idle();

    // k of zero counts as one
    set_config(0, 65535, 65535);
    send_elem(0, 0, 0, 5, 2, 0, 0);
    send_elem(0, 0, 0, 5, 2, 0, 0);
    send_elem(0, 0, 0, 6, 2, 0, 0);
    send_elem(0, 0, 0, 10, 2, 0, 0);
    send_elem(0, 1, 0, 0, 2, 0, 0);
    send_elem(0, 1, 7, 0, 2, 0, 0);
    send_elem(0, 1, 0, 0, 2, 0, 1);
    wait_idle();

    in_gap_pct  = 18;
    out_gap_pct = 75;
    set_config(1, 3000, 1500);
    mark = items_sent;
    while (items_sent < mark + 110) send_candidate(12);
    wait_idle();
    set_config($urandom_range(1, 127), $urandom_range(0, 65535), $urandom_range(0, 65535));
    mark = items_sent;
    while (items_sent < mark + 100) send_candidate(12);
    wait_idle();

    in_gap_pct  = 75;
    out_gap_pct = 18;
    set_config(64, 65535, 0);
    mark = items_sent;
    while (items_sent < mark + 110) send_candidate(12);
    wait_idle();
    set_config(127, 0, 65535);
    mark = items_sent;
    while (items_sent < mark + 100) send_candidate(12);
    wait_idle();

    in_gap_pct  = 0;
    out_gap_pct = 0;
    set_config(16, 2500, 4000);
    hold_left = HoldCycles;
    repeat (40) send_candidate(2);
    mark = items_sent;
    while (items_sent < mark + 100) send_candidate(12);
    wait_idle();

    set_config($urandom_range(0, 127), $urandom_range(0, 65535), $urandom_range(0, 65535));
    mark = items_sent;
    while (items_sent < mark + 120) send_candidate(12);
    wait_idle();

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sketch_hit_indel_substitution_check_unit.f]
rtl/shisc_pkg.sv
rtl/shisc_in_stage.sv
rtl/shisc_seg_track.sv
rtl/sketch_hit_indel_substitution_check_unit.sv
test/shisc_verdict_checker.sv
test/sketch_hit_indel_substitution_check_unit_tb.sv
